@@ hw/rtl/fct_pkg.sv @@
// Package for the future cell table: command, status and cell state codes,
// field widths and the word stored per cell in the cell memory.
// No dependencies.
package fct_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned HANDLE_W = 4;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned THREAD_W = 6;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_GET   = 2'd2,
		CMD_SET   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK    = 2'd0,
		RES_VALUE = 2'd1,
		RES_WAIT  = 2'd2,
		RES_ERROR = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		CELL_FREE     = 2'd0,
		CELL_ALLOC    = 2'd1,
		CELL_PRODUCED = 2'd2,
		CELL_WAITING  = 2'd3
	} cell_st_t;

	// One memory word per cell: the recorded consumer and the produced value.
	typedef struct packed {
		logic [THREAD_W-1:0] waiter;
		logic [VALUE_W-1:0]  value;
	} cell_word_t;

endpackage

@@ hw/rtl/future_cell_table.sv @@
// Future cell table: top level, holds the cell memory, the cell state flags,
// the round-robin free cell search and the output register.
// Depends on fct_pkg.
//
// Usage: one input channel (in_valid / in_stall) carries a command, handle,
// set_value and requester; one output channel (out_valid / out_stall) carries
// exactly one result item per input item, in order. Alloc claims the next free
// cell after the last one granted; get returns a produced value or records the
// requester as the waiter; set stores a value and releases a waiter; free
// releases a waiter and returns the cell.
// An accepted item waits in the read stage (command fields and rd_q) until the
// output register is free, then moves into the output register, which drives
// out_valid and the result until the receiver takes it.
// The block takes no new item until the last one has left the read stage. The
// cell memory is read at acceptance and written back when the item leaves the
// read stage, and the input stalls while that read-modify-write is in flight.
// Reset (arst_n low) frees every cell and clears the round-robin pointer at
// once; no clearing pass is needed, the block accepts items right after reset.
// When the receiver stalls, the result holds in the output register; a further
// item may be accepted and waits in the read stage until the output frees up.
module future_cell_table
	import fct_pkg::*;
#(
	parameter int unsigned CELLS   = 16,
	parameter int unsigned THREADS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [VALUE_W-1:0]  set_value,
	input  logic [THREAD_W-1:0] requester,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] result_handle,
	output logic [VALUE_W-1:0]  result_value,
	output logic                wake,
	output logic [THREAD_W-1:0] wake_thread,
	output logic [VALUE_W-1:0]  wake_value
);

	localparam int unsigned IDX_W = $clog2(CELLS);

	cell_st_t cell_st_q [CELLS];
	cell_word_t mem_q [CELLS];
	cell_word_t rd_q;
	logic [IDX_W-1:0] last_q;

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic [THREAD_W-1:0] req_s1;

	logic                out_valid_q;
	res_t                status_q;
	logic [HANDLE_W-1:0] rhandle_q;
	logic [VALUE_W-1:0]  rvalue_q;
	logic                wake_q;
	logic [THREAD_W-1:0] wthread_q;
	logic [VALUE_W-1:0]  wvalue_q;

	logic in_fire;
	logic done_s1;

	assign in_stall = valid_s1;
	assign in_fire  = in_valid && !in_stall;
	assign done_s1  = valid_s1 && (!out_valid_q || !out_stall);

	// Round-robin search: lowest free cell above the last grant, else lowest free.
	logic [CELLS-1:0] free_vec;
	logic [CELLS-1:0] upper_vec;
	logic [IDX_W-1:0] alloc_idx;
	logic             alloc_found;

	always_comb begin
		logic found_hi;
		logic [IDX_W-1:0] idx_hi;
		logic [IDX_W-1:0] idx_any;
		found_hi = 1'b0;
		idx_hi = '0;
		idx_any = '0;
		for (int i = CELLS - 1; i >= 0; i--) begin
			free_vec[i] = (cell_st_q[i] == CELL_FREE);
			upper_vec[i] = free_vec[i] && (IDX_W'(i) > last_q);
			if (upper_vec[i]) begin
				idx_hi = IDX_W'(i);
				found_hi = 1'b1;
			end
			if (free_vec[i]) begin
				idx_any = IDX_W'(i);
			end
		end
		alloc_found = |free_vec;
		alloc_idx = found_hi ? idx_hi : idx_any;
	end

	// Read-modify-write of the addressed cell.
	logic [IDX_W-1:0]    idx_s1;
	logic                hbig_s1;
	cell_st_t            cur_st;
	logic                bad_h;
	logic                bad_req;
	res_t                res_c;
	logic [HANDLE_W-1:0] rhandle_c;
	logic [VALUE_W-1:0]  rvalue_c;
	logic                wake_c;
	logic [THREAD_W-1:0] wthread_c;
	logic [VALUE_W-1:0]  wvalue_c;
	logic                st_we;
	logic [IDX_W-1:0]    st_idx;
	cell_st_t            st_new;
	logic                mem_we;
	cell_word_t          mem_wdata;
	logic                last_we;

	always_comb begin
		idx_s1 = IDX_W'(handle_s1);
		hbig_s1 = (32'(handle_s1) >= CELLS);
		cur_st = hbig_s1 ? CELL_FREE : cell_st_q[idx_s1];
		bad_h = (cur_st == CELL_FREE);
		bad_req = (32'(req_s1) >= THREADS);
		res_c = RES_OK;
		rhandle_c = '0;
		rvalue_c = '0;
		wake_c = 1'b0;
		wthread_c = '0;
		wvalue_c = '0;
		st_we = 1'b0;
		st_idx = idx_s1;
		st_new = CELL_FREE;
		mem_we = 1'b0;
		mem_wdata = rd_q;
		last_we = 1'b0;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (alloc_found) begin
					st_we = 1'b1;
					st_idx = alloc_idx;
					st_new = CELL_ALLOC;
					last_we = 1'b1;
					rhandle_c = HANDLE_W'(alloc_idx);
				end else begin
					res_c = RES_ERROR;
				end
			end
			CMD_FREE: begin
				if (bad_h) begin
					res_c = RES_ERROR;
				end else begin
					st_we = 1'b1;
					st_new = CELL_FREE;
					if (cur_st == CELL_WAITING) begin
						wake_c = 1'b1;
						wthread_c = rd_q.waiter;
					end
				end
			end
			CMD_GET: begin
				if (bad_h || bad_req) begin
					res_c = RES_ERROR;
				end else if (cur_st == CELL_PRODUCED) begin
					res_c = RES_VALUE;
					rvalue_c = rd_q.value;
				end else if (cur_st == CELL_ALLOC) begin
					res_c = RES_WAIT;
					st_we = 1'b1;
					st_new = CELL_WAITING;
					mem_we = 1'b1;
					mem_wdata.waiter = req_s1;
				end
			end
			CMD_SET: begin
				// A set on a bad handle is dropped and still answers ok.
				if (!bad_h) begin
					st_we = 1'b1;
					st_new = CELL_PRODUCED;
					mem_we = 1'b1;
					mem_wdata.value = value_s1;
					if (cur_st == CELL_WAITING) begin
						wake_c = 1'b1;
						wthread_c = rd_q.waiter;
						wvalue_c = value_s1;
					end
				end
			end
			default: begin
				res_c = RES_ERROR;
			end
		endcase
	end

	// Cell memory: read at acceptance, written back when the item completes.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q <= mem_q[IDX_W'(handle)];
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && mem_we) begin
			mem_q[idx_s1] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				cell_st_q[i] <= CELL_FREE;
			end
			last_q <= '0;
		end else if (done_s1) begin
			if (st_we) begin
				cell_st_q[st_idx] <= st_new;
			end
			if (last_we) begin
				last_q <= alloc_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd_t'(command);
			handle_s1 <= handle;
			value_s1 <= set_value;
			req_s1 <= requester;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			status_q <= res_c;
			rhandle_q <= rhandle_c;
			rvalue_q <= rvalue_c;
			wake_q <= wake_c;
			wthread_q <= wthread_c;
			wvalue_q <= wvalue_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_handle = rhandle_q;
	assign result_value  = rvalue_q;
	assign wake          = wake_q;
	assign wake_thread   = wthread_q;
	assign wake_value    = wvalue_q;

	// A successful alloc leaves the granted cell allocated and the pointer on it.
	a_alloc_claims: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && cmd_s1 == CMD_ALLOC && alloc_found
		|=> cell_st_q[$past(alloc_idx)] == CELL_ALLOC && last_q == $past(alloc_idx))
		else $error("alloc did not claim the granted cell");

	a_wake_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && wake_c |-> cmd_s1 == CMD_FREE || cmd_s1 == CMD_SET)
		else $error("wake raised by a command that cannot release a waiter");

	a_value_get: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && res_c == RES_VALUE |-> cmd_s1 == CMD_GET && cur_st == CELL_PRODUCED)
		else $error("value returned from a cell that is not produced");

	a_handle_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && cmd_s1 != CMD_ALLOC |-> rhandle_c == '0)
		else $error("result handle set by a command other than alloc");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !done_s1 |=> valid_s1 && $stable(handle_s1) && $stable(rd_q))
		else $error("item in the read stage lost while the output was stalled");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for future_cell_table: a directed opening, then weighted random
// commands under several idling phases, checked against an in-bench model of the cell table.
// Depends on fct_pkg and future_cell_table.
module testbench;
	import fct_pkg::*;

	localparam int NUM_CELLS    = 16;
	localparam int NUM_THREADS  = 64;
	localparam int RANDOM_ITEMS = 450;
	localparam int PHASE_LEN    = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [VALUE_W-1:0]  value;
		logic [THREAD_W-1:0] req;
	} request_t;

	typedef struct packed {
		res_t                st;
		logic [HANDLE_W-1:0] rhandle;
		logic [VALUE_W-1:0]  rvalue;
		logic                wake;
		logic [THREAD_W-1:0] wthread;
		logic [VALUE_W-1:0]  wvalue;
	} outcome_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command   = CMD_ALLOC;
	logic [HANDLE_W-1:0] handle    = '0;
	logic [VALUE_W-1:0]  set_value = '0;
	logic [THREAD_W-1:0] requester = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] result_handle;
	logic [VALUE_W-1:0]  result_value;
	logic                wake;
	logic [THREAD_W-1:0] wake_thread;
	logic [VALUE_W-1:0]  wake_value;

	request_t request_queue[$];
	outcome_t expected_outcomes[$];
	request_t current_req;
	outcome_t predicted;
	outcome_t oldest;

	// Model copy of the cell table.
	cell_st_t            cell_state_m[NUM_CELLS];
	logic [VALUE_W-1:0]  cell_value_m[NUM_CELLS];
	logic [THREAD_W-1:0] cell_waiter_m[NUM_CELLS];
	logic [HANDLE_W-1:0] last_granted_m = '0;

	int mismatches   = 0;
	int cycle_count  = 0;
	int accepted     = 0;
	int results_seen = 0;
	int total_items  = 0;
	int cmd_count[4] = '{0, 0, 0, 0};
	int waits_seen   = 0;
	int wakes_seen   = 0;
	int errors_seen  = 0;

	always #1 clk = ~clk;

	future_cell_table #(
		.CELLS(NUM_CELLS),
		.THREADS(NUM_THREADS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.handle(handle),
		.set_value(set_value),
		.requester(requester),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_handle(result_handle),
		.result_value(result_value),
		.wake(wake),
		.wake_thread(wake_thread),
		.wake_value(wake_value)
	);

	// Applies one command to the model table and returns the result it must produce.
	function automatic outcome_t resolve_future_op(request_t rq);
		outcome_t o;
		int c;
		logic bad;
		o.st      = RES_OK;
		o.rhandle = '0;
		o.rvalue  = '0;
		o.wake    = 1'b0;
		o.wthread = '0;
		o.wvalue  = '0;
		bad = (int'(rq.handle) >= NUM_CELLS) || (cell_state_m[rq.handle] == CELL_FREE);
		case (rq.cmd)
			CMD_ALLOC: begin
				o.st = RES_ERROR;
				for (int i = 1; i <= NUM_CELLS; i++) begin
					c = (int'(last_granted_m) + i) % NUM_CELLS;
					if (o.st == RES_ERROR && cell_state_m[c] == CELL_FREE) begin
						cell_state_m[c] = CELL_ALLOC;
						last_granted_m  = c[HANDLE_W-1:0];
						o.rhandle       = c[HANDLE_W-1:0];
						o.st            = RES_OK;
					end
				end
			end
			CMD_FREE: begin
				if (bad) begin
					o.st = RES_ERROR;
				end else begin
					if (cell_state_m[rq.handle] == CELL_WAITING) begin
						o.wake    = 1'b1;
						o.wthread = cell_waiter_m[rq.handle];
					end
					cell_state_m[rq.handle] = CELL_FREE;
				end
			end
			CMD_GET: begin
				if (bad || int'(rq.req) >= NUM_THREADS) begin
					o.st = RES_ERROR;
				end else if (cell_state_m[rq.handle] == CELL_PRODUCED) begin
					o.st     = RES_VALUE;
					o.rvalue = cell_value_m[rq.handle];
				end else if (cell_state_m[rq.handle] == CELL_ALLOC) begin
					cell_state_m[rq.handle]  = CELL_WAITING;
					cell_waiter_m[rq.handle] = rq.req;
					o.st = RES_WAIT;
				end
			end
			default: begin
				// A set on a bad handle is dropped without an error.
				if (!bad) begin
					cell_value_m[rq.handle] = rq.value;
					if (cell_state_m[rq.handle] == CELL_WAITING) begin
						o.wake    = 1'b1;
						o.wthread = cell_waiter_m[rq.handle];
						o.wvalue  = rq.value;
					end
					cell_state_m[rq.handle] = CELL_PRODUCED;
				end
			end
		endcase
		return o;
	endfunction

	function automatic int idle_pct(bit receiver);
		case ((accepted / PHASE_LEN) % 4)
			1: return receiver ? 0 : 56;
			2: return receiver ? 56 : 0;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_request(cmd_t cmd, int h, logic [VALUE_W-1:0] v, int rq);
		request_t r;
		r.cmd    = cmd;
		r.handle = h[HANDLE_W-1:0];
		r.value  = v;
		r.req    = rq[THREAD_W-1:0];
		request_queue.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch on result %0d: %s got %h expected %h",
				$realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Driver: the payload holds while stalled; a new item is taken only once the old one is gone.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				predicted = resolve_future_op(current_req);
				expected_outcomes.push_back(predicted);
				cmd_count[current_req.cmd]++;
				if (predicted.st == RES_WAIT)
					waits_seen++;
				if (predicted.st == RES_ERROR)
					errors_seen++;
				if (predicted.wake)
					wakes_seen++;
				accepted++;
			end
			if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
				current_req = request_queue.pop_front();
				in_valid  <= 1'b1;
				command   <= current_req.cmd;
				handle    <= current_req.handle;
				set_value <= current_req.value;
				requester <= current_req.req;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: each result is matched against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with no item outstanding, status",
						32'(status), '0);
				end else begin
					oldest = expected_outcomes.pop_front();
					compare_field("status", 32'(status), 32'(oldest.st));
					compare_field("result_handle", 32'(result_handle),
						32'(oldest.rhandle));
					compare_field("result_value", result_value, oldest.rvalue);
					compare_field("wake", 32'(wake), 32'(oldest.wake));
					compare_field("wake_thread", 32'(wake_thread),
						32'(oldest.wthread));
					compare_field("wake_value", wake_value, oldest.wvalue);
				end
				results_seen++;
			end
			out_stall <= ($urandom_range(99) < idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d items accepted",
				cycle_count, accepted, total_items);
			$display("future_cell_table test failed");
			$finish;
		end
	end

	initial begin
		int r;
		for (int i = 0; i < NUM_CELLS; i++) begin
			cell_state_m[i]  = CELL_FREE;
			cell_value_m[i]  = '0;
			cell_waiter_m[i] = '0;
		end

		// Bad handles on an empty table: get and free fail, set is dropped quietly.
		push_request(CMD_GET, 0, '0, 63);
		push_request(CMD_SET, 15, 32'h7FFF_FFFF, 0);
		push_request(CMD_FREE, 15, '1, 0);
		// Fill the table round-robin, then one more alloc finds it full.
		repeat (NUM_CELLS + 1)
			push_request(CMD_ALLOC, $urandom_range(15), $urandom(), $urandom_range(63));
		// Cell 0 was granted last: wait on it, get again while waiting, then produce it.
		push_request(CMD_GET, 0, '0, 63);
		push_request(CMD_GET, 0, '0, 0);
		push_request(CMD_SET, 0, 32'h8000_0000, 21);
		push_request(CMD_GET, 0, '0, 7);
		push_request(CMD_SET, 0, '1, 0);
		// A waiter released by free gets no value.
		push_request(CMD_GET, 5, '0, 42);
		push_request(CMD_FREE, 5, '0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(99);
			if (r < 20)
				push_request(CMD_ALLOC, $urandom_range(15), pick_value(), $urandom_range(63));
			else if (r < 36)
				push_request(CMD_FREE, $urandom_range(15), pick_value(), $urandom_range(63));
			else if (r < 68)
				push_request(CMD_GET, $urandom_range(15), pick_value(), $urandom_range(63));
			else
				push_request(CMD_SET, $urandom_range(15), pick_value(), $urandom_range(63));
		end
		total_items = request_queue.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_items || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d items (alloc %0d, free %0d, get %0d, set %0d), %0d results checked.",
			accepted, cmd_count[CMD_ALLOC], cmd_count[CMD_FREE], cmd_count[CMD_GET],
			cmd_count[CMD_SET], results_seen);
		$display("Consumers made to wait %0d times, released %0d times; %0d error answers.",
			waits_seen, wakes_seen, errors_seen);
		if (mismatches == 0) begin
			$display("future_cell_table test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("future_cell_table test failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/fct_pkg.sv
hw/rtl/future_cell_table.sv
dv/testbench.sv
